/* src/nsfc_pkg.sv */
// Shared types, character codes and helper functions for the NMEA sentence
// framer and checksum checker. Used by every module in src but nsfc_in_stage; depends on nothing.
`default_nettype none

package nsfc_pkg;

  // Default parameter values for the top level.
  localparam int unsigned MaxLineDefault   = 128;
  localparam int unsigned MaxFieldsDefault = 24;

  // Width of the sentence length counter; the user must keep MAX_LINE below 256, not enforced here.
  localparam int unsigned LenW = 8;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  localparam logic [23:0] TypeGga = 24'h474741;
  localparam logic [23:0] TypeRmc = 24'h524D43;
  localparam logic [23:0] TypeZda = 24'h5A4441;
  localparam logic [23:0] TypeTxt = 24'h545854;

  localparam logic [4:0] MinFieldsLong  = 5'd10;
  localparam logic [4:0] MinFieldsShort = 5'd5;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHECK = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_TOO_MANY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_GGA   = 3'd1,
    KIND_RMC   = 3'd2,
    KIND_ZDA   = 3'd3,
    KIND_TXT   = 3'd4
  } kind_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [4:0]  field_count;
    logic        meets_minimum;
    logic [31:0] sentence_total;
    logic [31:0] checksum_error_total;
  } result_t;

  // Value of an ASCII hex digit; bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 5'({1'b0, c[3:0]} + 5'd9);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/nsfc_in_stage.sv */
// Input register of the sentence checker: holds one received byte until the
// parser can take it. Depends on nothing else.
`default_nettype none

module nsfc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

/* src/nsfc_parser.sv */
// Sentence parser: framing, running XOR, trailer capture, field counting and
// the end-of-line evaluation with the two totals. Depends on nsfc_pkg.
`default_nettype none

module nsfc_parser #(
  parameter int unsigned MAX_LINE   = nsfc_pkg::MaxLineDefault,
  parameter int unsigned MAX_FIELDS = nsfc_pkg::MaxFieldsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire logic              step,
  input  wire logic [7:0]        byte_in,
  output logic                   res_valid,
  output nsfc_pkg::result_t      res
);

  localparam logic [nsfc_pkg::LenW-1:0] LenLimit = nsfc_pkg::LenW'(MAX_LINE - 1);
  localparam logic [4:0]                FieldLimit = 5'(MAX_FIELDS);

  logic                       enable_r;
  logic [nsfc_pkg::LenW-1:0]  len_r, len_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic                       star_r, star_nxt;
  logic [1:0]                 after_r, after_nxt;
  logic                       end_r, end_nxt;
  logic [15:0]                digits_r, digits_nxt;
  logic [4:0]                 comma_r, comma_nxt;
  logic                       first_done_r, first_done_nxt;
  logic [23:0]                tail_r, tail_nxt;
  logic [1:0]                 tlen_r, tlen_nxt;
  logic [31:0]                acc_r, acc_nxt;
  logic [31:0]                fail_r, fail_nxt;
  logic                       emit;

  // Fields of the sentence as it stands after this byte.
  logic                       body_star;
  logic [1:0]                 body_after;
  logic [15:0]                body_digits;
  logic [7:0]                 body_xor;
  logic [4:0]                 body_comma;
  logic                       body_first_done;
  logic [23:0]                body_tail;
  logic [1:0]                 body_tlen;

  logic                       is_end;
  logic [4:0]                 hi, lo;
  logic                       trailer_ok;
  nsfc_pkg::kind_t            kind;
  logic [4:0]                 count;

  assign is_end = (byte_in == nsfc_pkg::ChCr) || (byte_in == nsfc_pkg::ChLf);

  // Per-byte update of the sentence fields, ignoring framing.
  always_comb begin
    body_star       = star_r;
    body_after      = after_r;
    body_digits     = digits_r;
    body_xor        = xor_r;
    body_comma      = comma_r;
    body_first_done = first_done_r;
    body_tail       = tail_r;
    body_tlen       = tlen_r;
    if (!star_r) begin
      if (byte_in == nsfc_pkg::ChStar) begin
        body_star = 1'b1;
      end else begin
        body_xor = xor_r ^ byte_in;
        if (byte_in == nsfc_pkg::ChComma) begin
          if (comma_r != 5'd31) begin
            body_comma = comma_r + 5'd1;
          end
          body_first_done = 1'b1;
        end else if (!first_done_r) begin
          body_tail = {tail_r[15:0], byte_in};
          if (tlen_r != 2'd3) begin
            body_tlen = tlen_r + 2'd1;
          end
        end
      end
    end else if (!end_r && !is_end && after_r != 2'd2) begin
      body_digits = {digits_r[7:0], byte_in};
      body_after  = after_r + 2'd1;
    end
  end

  // End-of-line evaluation on the updated fields.
  always_comb begin
    hi = nsfc_pkg::hex_value(body_digits[15:8]);
    lo = nsfc_pkg::hex_value(body_digits[7:0]);
    trailer_ok = body_star && (body_after == 2'd2) && !hi[4] && !lo[4] &&
                 ({hi[3:0], lo[3:0]} == body_xor);
    kind = nsfc_pkg::KIND_OTHER;
    if (body_tlen == 2'd3) begin
      case (body_tail)
        nsfc_pkg::TypeGga: kind = nsfc_pkg::KIND_GGA;
        nsfc_pkg::TypeRmc: kind = nsfc_pkg::KIND_RMC;
        nsfc_pkg::TypeZda: kind = nsfc_pkg::KIND_ZDA;
        nsfc_pkg::TypeTxt: kind = nsfc_pkg::KIND_TXT;
        default:           kind = nsfc_pkg::KIND_OTHER;
      endcase
    end
    count = body_comma + 5'd1;
  end

  always_comb begin
    len_nxt        = len_r;
    xor_nxt        = xor_r;
    star_nxt       = star_r;
    after_nxt      = after_r;
    end_nxt        = end_r;
    digits_nxt     = digits_r;
    comma_nxt      = comma_r;
    first_done_nxt = first_done_r;
    tail_nxt       = tail_r;
    tlen_nxt       = tlen_r;
    acc_nxt        = acc_r;
    fail_nxt       = fail_r;
    emit           = 1'b0;

    res.status               = nsfc_pkg::STATUS_OK;
    res.kind                 = nsfc_pkg::KIND_OTHER;
    res.field_count          = 5'd0;
    res.meets_minimum        = 1'b0;

    if (step && enable_r) begin
      if (byte_in == nsfc_pkg::ChDollar) begin
        len_nxt        = '0;
        xor_nxt        = '0;
        star_nxt       = 1'b0;
        after_nxt      = '0;
        end_nxt        = 1'b0;
        digits_nxt     = '0;
        comma_nxt      = '0;
        first_done_nxt = 1'b0;
        tail_nxt       = '0;
        tlen_nxt       = '0;
        len_nxt        = nsfc_pkg::LenW'(1);
      end else if (len_r == '0) begin
        len_nxt = len_r;
      end else if (len_r >= LenLimit || byte_in == nsfc_pkg::ChLf) begin
        // An overlong line and a finished line both leave the parser idle.
        len_nxt        = '0;
        xor_nxt        = '0;
        star_nxt       = 1'b0;
        after_nxt      = '0;
        end_nxt        = 1'b0;
        digits_nxt     = '0;
        comma_nxt      = '0;
        first_done_nxt = 1'b0;
        tail_nxt       = '0;
        tlen_nxt       = '0;
        if (len_r < LenLimit) begin
          emit = 1'b1;
          if (!trailer_ok) begin
            res.status = nsfc_pkg::STATUS_BAD_CHECK;
            fail_nxt   = fail_r + 32'd1;
          end else if (body_tlen == 2'd0 && !body_first_done) begin
            res.status = nsfc_pkg::STATUS_EMPTY;
          end else if (body_comma >= FieldLimit) begin
            res.status = nsfc_pkg::STATUS_TOO_MANY;
          end else begin
            acc_nxt         = acc_r + 32'd1;
            res.kind        = kind;
            res.field_count = count;
            if (kind == nsfc_pkg::KIND_GGA || kind == nsfc_pkg::KIND_RMC) begin
              res.meets_minimum = count >= nsfc_pkg::MinFieldsLong;
            end else if (kind == nsfc_pkg::KIND_ZDA || kind == nsfc_pkg::KIND_TXT) begin
              res.meets_minimum = count >= nsfc_pkg::MinFieldsShort;
            end
          end
        end
      end else begin
        len_nxt        = len_r + nsfc_pkg::LenW'(1);
        xor_nxt        = body_xor;
        star_nxt       = body_star;
        after_nxt      = body_after;
        digits_nxt     = body_digits;
        comma_nxt      = body_comma;
        first_done_nxt = body_first_done;
        tail_nxt       = body_tail;
        tlen_nxt       = body_tlen;
        end_nxt        = end_r || is_end;
      end
    end

    res.sentence_total       = acc_nxt;
    res.checksum_error_total = fail_nxt;
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      len_r        <= '0;
      xor_r        <= '0;
      star_r       <= 1'b0;
      after_r      <= '0;
      end_r        <= 1'b0;
      digits_r     <= '0;
      comma_r      <= '0;
      first_done_r <= 1'b0;
      tail_r       <= '0;
      tlen_r       <= '0;
      acc_r        <= '0;
      fail_r       <= '0;
    end else if (cfg_wr_en) begin
      // A configuration write clears the parser and keeps the totals.
      enable_r     <= cfg_wr_data;
      len_r        <= '0;
      xor_r        <= '0;
      star_r       <= 1'b0;
      after_r      <= '0;
      end_r        <= 1'b0;
      digits_r     <= '0;
      comma_r      <= '0;
      first_done_r <= 1'b0;
      tail_r       <= '0;
      tlen_r       <= '0;
    end else begin
      len_r        <= len_nxt;
      xor_r        <= xor_nxt;
      star_r       <= star_nxt;
      after_r      <= after_nxt;
      end_r        <= end_nxt;
      digits_r     <= digits_nxt;
      comma_r      <= comma_nxt;
      first_done_r <= first_done_nxt;
      tail_r       <= tail_nxt;
      tlen_r       <= tlen_nxt;
      acc_r        <= acc_nxt;
      fail_r       <= fail_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/nsfc_out_stage.sv */
// Result register of the sentence checker: holds one result until the
// consumer takes it. Depends on nsfc_pkg.
`default_nettype none

module nsfc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire nsfc_pkg::result_t load_res,
  output logic                   has_room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nsfc_pkg::result_t      held_res
);

  logic              valid_r;
  logic              valid_nxt;
  nsfc_pkg::result_t res_r;

  assign has_room  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held_res  = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

/* src/nmea_sentence_framer_checker_unit.sv */
// NMEA 0183 sentence framer and checksum checker. One received byte is one
// input transaction; a line feed that closes a sentence gives one result
// transaction with status, sentence kind, field count, minimum-field flag and
// the two wrapping totals. Bytes pass an input register, combinational parser
// logic and a result register; out_valid rises once the line feed has reached
// the result register. The block takes a byte every clock cycle unless the
// input stalls, which it does only while a result waits at the output.
// Writing cfg_wr_data with cfg_wr_en sets the enable and clears any partial
// sentence; the totals survive it.
// Depends on nsfc_pkg, nsfc_in_stage, nsfc_parser and nsfc_out_stage.
`default_nettype none

module nmea_sentence_framer_checker_unit #(
  parameter int unsigned MAX_LINE   = nsfc_pkg::MaxLineDefault,
  parameter int unsigned MAX_FIELDS = nsfc_pkg::MaxFieldsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [2:0]       out_kind,
  output logic [4:0]       out_field_count,
  output logic             out_meets_minimum,
  output logic [31:0]      out_sentence_total,
  output logic [31:0]      out_checksum_error_total
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              has_room;
  logic              step;
  logic              res_valid;
  nsfc_pkg::result_t res;
  nsfc_pkg::result_t out_res;

  assign step = held_valid && has_room;

  nsfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  nsfc_parser #(
    .MAX_LINE   (MAX_LINE),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .byte_in     (held_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  nsfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held_res  (out_res)
  );

  assign out_status               = out_res.status;
  assign out_kind                 = out_res.kind;
  assign out_field_count          = out_res.field_count;
  assign out_meets_minimum        = out_res.meets_minimum;
  assign out_sentence_total       = out_res.sentence_total;
  assign out_checksum_error_total = out_res.checksum_error_total;

endmodule

`default_nettype wire

/* sim/nmea_sentence_framer_checker_unit_tb.sv */
// Self-checking testbench for nmea_sentence_framer_checker_unit: directed sentences, then
// random well-formed and broken NMEA traffic with bursty input and a stalling receiver.
// Depends on nsfc_pkg and the unit itself; results are checked against an in-bench predictor.
module nmea_sentence_framer_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLine   = nsfc_pkg::MaxLineDefault;
  localparam int MaxFields = nsfc_pkg::MaxFieldsDefault;
  localparam int DirRows   = 23;

  typedef struct {
    string             text;
    bit                framed;
    int                fill;
    bit                typed;
    nsfc_pkg::status_t status;
    nsfc_pkg::kind_t   kind;
    int                count;
    bit                meets;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [2:0]  out_kind;
  logic [4:0]  out_field_count;
  logic        out_meets_minimum;
  logic [31:0] out_sentence_total;
  logic [31:0] out_checksum_error_total;

  // Predictor state.
  logic        rx_enable;
  logic [7:0]  line_len;
  logic [7:0]  line_xor;
  logic        star_found;
  logic [1:0]  digit_count;
  logic        eol_found;
  logic [15:0] digit_pair;
  logic [4:0]  comma_total;
  logic        head_done;
  logic [23:0] head_tail;
  logic [1:0]  head_len;
  logic [31:0] ok_total;
  logic [31:0] bad_total;

  nsfc_pkg::result_t pending_results[$];
  logic [7:0]  line_buf[$];
  logic [7:0]  build_xor;
  int          sent_items;
  int          burst_left;
  int          mismatch_count;
  dir_row_t    dir_rows[DirRows];

  // Hand-written expectation for the directed row being sent.
  bit                row_typed;
  nsfc_pkg::status_t row_status;
  nsfc_pkg::kind_t   row_kind;
  logic [4:0]        row_count;
  logic              row_meets;

  nsfc_pkg::result_t want_result;

  nmea_sentence_framer_checker_unit #(
    .MAX_LINE   (MaxLine),
    .MAX_FIELDS (MaxFields)
  ) i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_byte                  (in_byte),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_status               (out_status),
    .out_kind                 (out_kind),
    .out_field_count          (out_field_count),
    .out_meets_minimum        (out_meets_minimum),
    .out_sentence_total       (out_sentence_total),
    .out_checksum_error_total (out_checksum_error_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void clear_sentence();
    line_len    = '0;
    line_xor    = '0;
    star_found  = 1'b0;
    digit_count = '0;
    eol_found   = 1'b0;
    digit_pair  = '0;
    comma_total = '0;
    head_done   = 1'b0;
    head_tail   = '0;
    head_len    = '0;
  endfunction

  // Advances the sentence parser by one accepted byte and queues the result a line feed gives.
  function automatic void sentence_step(input logic [7:0] b);
    logic              line_end;
    logic [4:0]        hi;
    logic [4:0]        lo;
    nsfc_pkg::result_t r;
    line_end = (b == nsfc_pkg::ChCr) || (b == nsfc_pkg::ChLf);
    if (!rx_enable) return;
    if (b == nsfc_pkg::ChDollar) begin
      clear_sentence();
      line_len = 8'd1;
      return;
    end
    if (line_len == '0) return;
    if (int'(line_len) >= MaxLine - 1) begin
      clear_sentence();
      return;
    end
    line_len = line_len + 8'd1;
    if (!star_found) begin
      if (b == nsfc_pkg::ChStar) begin
        star_found = 1'b1;
      end else begin
        line_xor = line_xor ^ b;
        if (b == nsfc_pkg::ChComma) begin
          if (comma_total != 5'd31) comma_total = comma_total + 5'd1;
          head_done = 1'b1;
        end else if (!head_done) begin
          head_tail = {head_tail[15:0], b};
          if (head_len != 2'd3) head_len = head_len + 2'd1;
        end
      end
    end else if (!eol_found && !line_end && digit_count < 2'd2) begin
      digit_pair  = {digit_pair[7:0], b};
      digit_count = digit_count + 2'd1;
    end
    if (line_end) eol_found = 1'b1;
    if (b != nsfc_pkg::ChLf) return;

    r = '0;
    r.status = nsfc_pkg::STATUS_OK;
    r.kind = nsfc_pkg::KIND_OTHER;
    hi = hex_digit(digit_pair[15:8]);
    lo = hex_digit(digit_pair[7:0]);
    if (!(star_found && digit_count == 2'd2 && !hi[4] && !lo[4] &&
          {hi[3:0], lo[3:0]} == line_xor)) begin
      r.status  = nsfc_pkg::STATUS_BAD_CHECK;
      bad_total = bad_total + 32'd1;
    end else if (head_len == '0 && !head_done) begin
      r.status = nsfc_pkg::STATUS_EMPTY;
    end else if (comma_total >= 5'(MaxFields)) begin
      r.status = nsfc_pkg::STATUS_TOO_MANY;
    end else begin
      ok_total = ok_total + 32'd1;
      if (head_len == 2'd3) begin
        case (head_tail)
          nsfc_pkg::TypeGga: r.kind = nsfc_pkg::KIND_GGA;
          nsfc_pkg::TypeRmc: r.kind = nsfc_pkg::KIND_RMC;
          nsfc_pkg::TypeZda: r.kind = nsfc_pkg::KIND_ZDA;
          nsfc_pkg::TypeTxt: r.kind = nsfc_pkg::KIND_TXT;
          default:           r.kind = nsfc_pkg::KIND_OTHER;
        endcase
      end
      r.field_count = comma_total + 5'd1;
      case (r.kind)
        nsfc_pkg::KIND_GGA, nsfc_pkg::KIND_RMC:
          r.meets_minimum = (r.field_count >= nsfc_pkg::MinFieldsLong);
        nsfc_pkg::KIND_ZDA, nsfc_pkg::KIND_TXT:
          r.meets_minimum = (r.field_count >= nsfc_pkg::MinFieldsShort);
        default:
          r.meets_minimum = 1'b0;
      endcase
    end
    if (row_typed) begin
      r.status        = row_status;
      r.kind          = row_kind;
      r.field_count   = row_count;
      r.meets_minimum = row_meets;
    end
    r.sentence_total       = ok_total;
    r.checksum_error_total = bad_total;
    pending_results.push_back(r);
    clear_sentence();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got status %0d",
                 $time, out_status);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("status", 32'(want_result.status), 32'(out_status));
        check_field("kind", 32'(want_result.kind), 32'(out_kind));
        check_field("field_count", 32'(want_result.field_count), 32'(out_field_count));
        check_field("meets_minimum", 32'(want_result.meets_minimum), 32'(out_meets_minimum));
        check_field("sentence_total", want_result.sentence_total, out_sentence_total);
        check_field("checksum_error_total", want_result.checksum_error_total,
                    out_checksum_error_total);
      end
    end
  end

  // The receiver cycles through its own stall patterns, including stretches of no stalls.
  initial begin
    int cyc;
    int mode;
    out_ready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 128 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 2) != 0);
        2:       out_ready <= ((cyc % 7) >= 3);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
      cyc++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sentence_step(b);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_line();
    int j;
    for (j = 0; j < line_buf.size(); j++) send_byte(line_buf[j]);
  endtask

  // Holds the input until every expected result has arrived and the pipeline has emptied.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    rx_enable = v;
    clear_sentence();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void push_payload(input logic [7:0] c);
    line_buf.push_back(c);
    build_xor = build_xor ^ c;
  endfunction

  function automatic void push_check(input logic [7:0] sum, input bit lower);
    line_buf.push_back(nsfc_pkg::ChStar);
    line_buf.push_back(hex_char(sum[7:4], lower));
    line_buf.push_back(hex_char(sum[3:0], lower));
  endfunction

  // A tilde in directed text stands for a zero byte.
  function automatic logic [7:0] text_byte(input string s, input int j);
    return (s[j] == 8'h7E) ? 8'h00 : s[j];
  endfunction

  function automatic logic [7:0] field_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h30, 8'h5A));
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = 8'h2F;
      1:       c = 8'h3A;
      2:       c = 8'h40;
      3:       c = 8'h47;
      4:       c = 8'h60;
      5:       c = 8'h67;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (hex_digit(c) != 5'h10) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  function automatic void build_random_sentence();
    int nf;
    int pick;
    int i;
    logic [7:0] sum;
    line_buf.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    line_buf.push_back(nsfc_pkg::ChDollar);
    build_xor = '0;
    case ($urandom_range(0, 7))
      0: begin push_payload("G"); push_payload("P"); end
      1: begin push_payload("G"); push_payload("N"); end
      2: repeat ($urandom_range(1, 3)) push_payload(8'($urandom_range(8'h41, 8'h5A)));
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0: begin push_payload("G"); push_payload("G"); push_payload("A"); end
      1: begin push_payload("R"); push_payload("M"); push_payload("C"); end
      2: begin push_payload("Z"); push_payload("D"); push_payload("A"); end
      3: begin push_payload("T"); push_payload("X"); push_payload("T"); end
      4: ;
      default: repeat ($urandom_range(1, 5)) push_payload(8'($urandom_range(8'h41, 8'h5A)));
    endcase
    pick = $urandom_range(0, 9);
    nf = (pick < 7) ? $urandom_range(1, 12) : ((pick < 9) ? $urandom_range(20, 27) : 1);
    for (i = 1; i < nf; i++) begin
      push_payload(nsfc_pkg::ChComma);
      repeat ((nf > 12) ? $urandom_range(0, 2) : $urandom_range(0, 6))
        push_payload(field_char());
    end
    // Sentences that run past the length limit.
    if ($urandom_range(0, 24) == 0)
      repeat ($urandom_range(100, 130)) push_payload(8'($urandom_range(8'h30, 8'h39)));
    // A sentence cut short is abandoned by the next dollar sign.
    if ($urandom_range(0, 19) == 0) return;
    sum = build_xor;
    pick = $urandom_range(0, 11);
    if (pick <= 6) begin
      push_check(sum, 1'b0);
    end else if (pick == 7) begin
      push_check(sum, 1'b1);
    end else if (pick == 8) begin
      push_check(sum ^ 8'($urandom_range(1, 255)), 1'b0);
    end else if (pick == 9) begin
      push_check(sum, 1'b0);
      line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] = non_hex_char();
    end else if (pick == 10) begin
      if ($urandom_range(0, 1) == 1) line_buf.push_back(nsfc_pkg::ChStar);
    end else begin
      line_buf.push_back(nsfc_pkg::ChStar);
      line_buf.push_back(hex_char(sum[7:4], 1'b0));
    end
    if ($urandom_range(0, 9) == 0) line_buf.push_back(nsfc_pkg::ChStar);
    if ($urandom_range(0, 3) != 0) line_buf.push_back(nsfc_pkg::ChCr);
    line_buf.push_back(nsfc_pkg::ChLf);
  endfunction

  task automatic random_phase(input int target);
    while (sent_items < target) begin
      build_random_sentence();
      send_line();
    end
  endtask

  initial begin
    int i;
    int j;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_byte     = '0;
    rx_enable   = 1'b0;
    ok_total    = '0;
    bad_total   = '0;
    row_typed   = 1'b0;
    sent_items  = 0;
    burst_left  = 0;
    mismatch_count = 0;
    clear_sentence();

    dir_rows = '{
      '{"junk*00\r\n", 1'b0, 0, 1'b0,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"GPGGA,1,2,3,4,5,6,7,8,9", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_GGA, 10, 1'b1},
      '{"GNRMC,a,b", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_RMC, 3, 1'b0},
      '{"GPZDA,1,2,3,4", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_ZDA, 5, 1'b1},
      '{"GPTXT,1,2,3", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_TXT, 4, 1'b0},
      '{"GA", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 1, 1'b0},
      '{"$J*4a\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 1, 1'b0},
      '{"$J*4B\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_BAD_CHECK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$J*4G\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_BAD_CHECK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$J\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_BAD_CHECK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$J*4\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_BAD_CHECK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$J\r*4A\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_BAD_CHECK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$*00\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_EMPTY, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$J*4A*7\r\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 1, 1'b0},
      '{"A,B,C,D,E,F,G,H,I,J,K,L,M,N,O,P,Q,R,S,T,U,V,W,X", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 24, 1'b0},
      '{"A,B,C,D,E,F,G,H,I,J,K,L,M,N,O,P,Q,R,S,T,U,V,W,X,Y", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_TOO_MANY, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$GPGGA,12,34", 1'b0, 0, 1'b0,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"GP~GA,1", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 2, 1'b0},
      '{"\377\200,1", 1'b1, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 2, 1'b0},
      '{"G", 1'b1, 120, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 1, 1'b0},
      '{"G", 1'b1, 121, 1'b0,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 0, 1'b0},
      '{"$,*2C\n", 1'b0, 0, 1'b1,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 2, 1'b0},
      '{"GPGGA,1,2,3,4,5,6,7,8", 1'b1, 0, 1'b0,
        nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 0, 1'b0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_enable(1'b1);

    for (i = 0; i < DirRows; i++) begin
      line_buf.delete();
      if (dir_rows[i].framed) begin
        line_buf.push_back(nsfc_pkg::ChDollar);
        build_xor = '0;
        for (j = 0; j < dir_rows[i].text.len(); j++)
          push_payload(text_byte(dir_rows[i].text, j));
        repeat (dir_rows[i].fill) push_payload("A");
        push_check(build_xor, 1'b0);
        line_buf.push_back(nsfc_pkg::ChCr);
        line_buf.push_back(nsfc_pkg::ChLf);
      end else begin
        for (j = 0; j < dir_rows[i].text.len(); j++)
          line_buf.push_back(text_byte(dir_rows[i].text, j));
      end
      row_typed  = dir_rows[i].typed;
      row_status = dir_rows[i].status;
      row_kind   = dir_rows[i].kind;
      row_count  = 5'(dir_rows[i].count);
      row_meets  = dir_rows[i].meets;
      send_line();
    end
    row_typed = 1'b0;

    random_phase(700);

    // Rewriting the enable in the middle of a sentence must discard it.
    line_buf.delete();
    for (j = 0; j < 10; j++) line_buf.push_back(text_byte("$GPGGA,1,2", j));
    send_line();
    wait_drained();
    write_enable(1'b1);
    random_phase(1300);

    // While disabled every byte is dropped.
    wait_drained();
    write_enable(1'b0);
    repeat (6) begin
      build_random_sentence();
      send_line();
    end
    wait_drained();
    write_enable(1'b1);
    random_phase(1950);

    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
